>>> hdl/cmra_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the contiguous minor range allocator.
// Used by the channel interfaces and the allocator core; no dependencies.
package cmra_pkg;

    // Default slot table depth
    localparam int DEF_TABLE_DEPTH = 256;

    // Field widths
    localparam int KIND_W = 2;
    localparam int LEN_W  = 9;
    localparam int NUM_W  = 20;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 2;

    // Slot states
    localparam logic [SLOT_W-1:0] SLOT_FREE     = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_RESERVED = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_IN_USE   = 2'd2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_RUN  = 2'd2;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_SLOTS_IN_USE  = 1'b0;  // byte address 0
    localparam logic REG_NUMBER_OFFSET = 1'b1;  // byte address 4

    // Register reset values
    localparam logic [LEN_W-1:0] SLOTS_RESET  = 9'd256;
    localparam logic [NUM_W-1:0] OFFSET_RESET = 20'd0;

endpackage

>>> hdl/cmra_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake plus the allocator request fields.
// Depends on cmra_pkg.
interface cmra_req_if import cmra_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  run_length;
    logic [NUM_W-1:0]  range_start;
    logic              mark_in_use;

    modport source (
        output valid, kind, run_length, range_start, mark_in_use,
        input  ready
    );

    modport sink (
        input  valid, kind, run_length, range_start, mark_in_use,
        output ready
    );

endinterface

>>> hdl/cmra_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake plus status and granted start.
// Depends on cmra_pkg.
interface cmra_rsp_if import cmra_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  granted_start;

    modport source (
        output valid, status, granted_start,
        input  ready
    );

    modport sink (
        input  valid, status, granted_start,
        output ready
    );

endinterface

>>> hdl/cmra_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmra_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/contiguous_minor_range_allocator_core.sv
`timescale 1ns / 1ps
// First-fit contiguous run allocator over a slot table held in one RAM.
// Depends on cmra_pkg, cmra_req_if, cmra_rsp_if and cmra_ram.
//
// The block handles one request at a time; the slot table RAM has a single
// read and a single write port, and the sequencer touches one slot per cycle.
// After reset a clearing pass writes every slot free, during which no
// request is accepted (configuration writes are taken).
// An allocate scans from slot 0 one slot per cycle up to the end of the
// first fitting run (at most the usable size), then writes run_length slots;
// when no run fits it answers with the no-run status. A claim reads its
// range then writes it in use, or stops with the invalid status when it
// meets a slot that is not reserved; a free writes its range free.
// Rejected requests go straight to the response. A response waits in an
// output register; a new request is taken once the previous result is
// registered.
module contiguous_minor_range_allocator_core
    import cmra_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cmra_req_if.sink              i_req,
    cmra_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WRITE = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // Control registers
    t_state            r_state,     n_state;
    logic [LEN_W-1:0]  r_slots;
    logic [NUM_W-1:0]  r_offset;
    logic [CW-1:0]     r_ptr,       n_ptr;
    logic              r_pend,      n_pend;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic [KIND_W-1:0] r_kind,      n_kind;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [NUM_W-1:0]  r_start,     n_start;
    logic              r_mark,      n_mark;
    logic [CW-1:0]     r_end,       n_end;
    logic [CW-1:0]     r_dpos,      n_dpos;
    logic [LEN_W-1:0]  r_run,       n_run;
    logic [CW-1:0]     r_first,     n_first;
    logic [SLOT_W-1:0] r_code,      n_code;
    logic [STAT_W-1:0] r_status,    n_status;
    logic              r_grant,     n_grant;
    logic [STAT_W-1:0] r_out_status,n_out_status;
    logic [NUM_W-1:0]  r_out_start, n_out_start;

    // RAM signals
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [SLOT_W-1:0] w_wdata;
    logic [SLOT_W-1:0] w_rdata;

    // Derived values
    logic [CW-1:0]     w_size;
    logic [NUM_W:0]    w_diff;
    logic [NUM_W:0]    w_range_end;
    logic              w_issue;
    logic [CW-1:0]     w_ptr_inc;
    logic              w_cfg_wr;

    // Usable size, limited to the table depth
    always_comb begin
        if (SW'(r_slots) > SW'(TABLE_DEPTH)) begin
            w_size = CW'(TABLE_DEPTH);
        end else begin
            w_size = CW'(r_slots);
        end
    end

    // Range translation for claim and free
    assign w_diff      = {1'b0, r_start} - {1'b0, r_offset};
    assign w_range_end = {1'b0, w_diff[NUM_W-1:0]} + (NUM_W + 1)'(r_len);

    assign w_issue   = (r_ptr < r_end);
    assign w_ptr_inc = r_ptr + CW'(1);

    // Slot table
    cmra_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_pend       = 1'b0;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_kind       = r_kind;
        n_len        = r_len;
        n_start      = r_start;
        n_mark       = r_mark;
        n_end        = r_end;
        n_dpos       = r_dpos;
        n_run        = r_run;
        n_first      = r_first;
        n_code       = r_code;
        n_status     = r_status;
        n_grant      = r_grant;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        w_we         = 1'b0;
        w_waddr      = r_ptr[AW-1:0];
        w_wdata      = r_code;

        case (r_state)
            // Clear the table after reset, one slot a cycle
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = SLOT_FREE;
                if (r_ptr == CW'(TABLE_DEPTH - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end

            // Take a request
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = i_req.kind;
                    n_len    = i_req.run_length;
                    n_start  = i_req.range_start;
                    n_mark   = i_req.mark_in_use;
                    n_grant  = 1'b0;
                    n_status = ST_INVALID;
                    n_state  = S_CHECK;
                end
            end

            // Validate and set up the scan or write
            S_CHECK: begin
                n_state = S_FIN;
                n_run   = '0;
                if (r_len != '0) begin
                    case (r_kind)
                        KIND_ALLOC: begin
                            if (SW'(r_len) <= SW'(w_size)) begin
                                n_ptr   = '0;
                                n_end   = w_size;
                                n_first = '0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_CLAIM, KIND_FREE: begin
                            if (!w_diff[NUM_W] &&
                                (w_range_end <= (NUM_W + 1)'(w_size))) begin
                                n_ptr   = CW'(w_diff[NUM_W-1:0]);
                                n_first = CW'(w_diff[NUM_W-1:0]);
                                n_end   = CW'(w_range_end);
                                if (r_kind == KIND_FREE) begin
                                    n_code   = SLOT_FREE;
                                    n_status = ST_OK;
                                    n_state  = S_WRITE;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end

            // Read one slot a cycle; examine the slot read last cycle
            S_SCAN: begin
                if (w_issue) begin
                    n_ptr  = w_ptr_inc;
                    n_pend = 1'b1;
                    n_dpos = r_ptr;
                end
                if (r_pend) begin
                    if (r_kind == KIND_ALLOC) begin
                        if (w_rdata == SLOT_FREE) begin
                            if (r_run + LEN_W'(1) == r_len) begin
                                // run complete
                                n_pend   = 1'b0;
                                n_ptr    = r_first;
                                n_end    = CW'(SW'(r_first) + SW'(r_len));
                                n_code   = r_mark ? SLOT_IN_USE : SLOT_RESERVED;
                                n_status = ST_OK;
                                n_grant  = 1'b1;
                                n_state  = S_WRITE;
                            end else begin
                                n_run = r_run + LEN_W'(1);
                            end
                        end else begin
                            // skip past the occupied slot
                            n_run   = '0;
                            n_first = r_dpos + CW'(1);
                        end
                    end else if (w_rdata != SLOT_RESERVED) begin
                        n_pend   = 1'b0;
                        n_status = ST_INVALID;
                        n_state  = S_FIN;
                    end
                end else if (!w_issue) begin
                    if (r_kind == KIND_ALLOC) begin
                        n_status = ST_NO_RUN;
                        n_state  = S_FIN;
                    end else begin
                        n_ptr    = r_first;
                        n_code   = SLOT_IN_USE;
                        n_status = ST_OK;
                        n_state  = S_WRITE;
                    end
                end
            end

            // Mark the range, one slot a cycle
            S_WRITE: begin
                w_we = 1'b1;
                if (w_ptr_inc >= r_end) begin
                    n_state = S_FIN;
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end

            // Load the response register once it is free
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_start  = r_grant ? (r_offset + NUM_W'(r_first)) : '0;
                    n_ptr        = '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration write strobe
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_slots     <= SLOTS_RESET;
            r_offset    <= OFFSET_RESET;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_SLOTS_IN_USE:  r_slots  <= pwdata[LEN_W-1:0];
                    REG_NUMBER_OFFSET: r_offset <= pwdata[NUM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Request and response payload
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_len        <= n_len;
        r_start      <= n_start;
        r_mark       <= n_mark;
        r_end        <= n_end;
        r_dpos       <= n_dpos;
        r_run        <= n_run;
        r_first      <= n_first;
        r_code       <= n_code;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
    end

    // Configuration read
    always_comb begin
        case (paddr[2])
            REG_SLOTS_IN_USE:  prdata = CFG_DATA_W'(r_slots);
            REG_NUMBER_OFFSET: prdata = CFG_DATA_W'(r_offset);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Channel outputs
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_start = r_out_start;

endmodule
